// ===== src/effect_slot_manager_defines.svh =====
// assertion macros for the effect slot manager
`ifndef EFFECT_SLOT_MANAGER_DEFINES_SVH
`define EFFECT_SLOT_MANAGER_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst is high
`define ESM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("effect slot manager check failed");

// next-cycle implication, checked on clk, off while rst is high
`define ESM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("effect slot manager check failed");

`endif

// ===== src/esm_pkg.sv =====
// types, codes and constants shared by the effect slot manager
`timescale 1ns / 1ps
`default_nettype none
package esm_pkg;

  // number of effect slots, numbered 1..MAX_SLOTS
  localparam int MAX_SLOTS = 16;
  // width of a slot number, zero meaning no slot
  localparam int SLOT_W = $clog2(MAX_SLOTS + 1);

  typedef logic [MAX_SLOTS-1:0] slot_mask_t;
  typedef logic [SLOT_W-1:0]    slot_num_t;

  // host commands
  typedef enum logic [3:0] {
    CMD_CREATE     = 4'd0,
    CMD_START      = 4'd1,
    CMD_START_SOLO = 4'd2,
    CMD_STOP       = 4'd3,
    CMD_FREE       = 4'd4,
    CMD_FREE_ALL   = 4'd5,
    CMD_ENABLE     = 4'd6,
    CMD_DISABLE    = 4'd7,
    CMD_STOP_ALL   = 4'd8,
    CMD_PAUSE      = 4'd9,
    CMD_RESUME     = 4'd10
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_POOL_TOTAL = 1'b0,
    REG_BLOCK_COST = 1'b1
  } reg_idx_t;

  // free with this index releases every slot
  localparam logic [7:0] FREE_ALL_INDEX = 8'hFF;

  localparam logic [15:0] POOL_TOTAL_RESET = 16'd4096;
  localparam logic [11:0] BLOCK_COST_RESET = 12'd64;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] effect_index;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  new_index;
    logic [15:0] pool_left;
    logic [15:0] allocated_mask;
    logic [15:0] playing_mask;
    logic        actuators_on;
    logic        paused;
  } result_item_t;

endpackage
`default_nettype wire

// ===== src/effect_slot_manager.sv =====
// effect slot manager: lowest free slot allocator with pool accounting
//
//  channel   | signals                            | transfer when
//  ----------+------------------------------------+------------------------------
//  command   | start, busy, command               | start high and busy low
//  result    | result_valid, result               | every cycle result_valid is high
//  config    | cfg_valid, cfg_ready, cfg_index,   | cfg_valid and cfg_ready high
//            | cfg_data                           |
//
//  a command is registered into in_q at its transfer, its result is registered
//  from in_q into result and transfers while result_valid is high; one command
//  per cycle, set by the single decode and update stage
//  the slot masks, pool and flags update in the same stage, so each command sees
//  all earlier ones. busy is high for one cycle after reset, then stays low
//  results are strobed for one cycle; the receiver has no way to stall them
`timescale 1ns / 1ps
`default_nettype none
`include "effect_slot_manager_defines.svh"
module effect_slot_manager (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire esm_pkg::cmd_item_t   command,
  output logic                      result_valid,
  output esm_pkg::result_item_t     result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  // configuration registers
  logic [15:0] pool_total;
  logic [11:0] block_cost;

  // input register
  logic                in_valid;
  esm_pkg::cmd_item_t  in_q;

  // slot and device state
  esm_pkg::slot_mask_t slot_allocated, slot_allocated_next;
  esm_pkg::slot_mask_t slot_playing, slot_playing_next;
  logic [15:0]         pool_available, pool_available_next;
  logic                actuator_enable, actuator_enable_next;
  logic                pause_flag, pause_flag_next;

  // decode signals
  esm_pkg::status_t    status_next;
  esm_pkg::slot_num_t  given;
  logic                found;
  logic                idx_ok;
  esm_pkg::slot_mask_t sel;
  logic [16:0]         credit_sum;

  assign cfg_ready = ~busy;

  // busy only right after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_total <= esm_pkg::POOL_TOTAL_RESET;
      block_cost <= esm_pkg::BLOCK_COST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (esm_pkg::reg_idx_t'(cfg_index))
        esm_pkg::REG_POOL_TOTAL: pool_total <= cfg_data;
        esm_pkg::REG_BLOCK_COST: block_cost <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_q <= command;
    end
  end

  // lowest free slot search
  always_comb begin
    found = 1'b0;
    given = '0;
    for (int k = esm_pkg::MAX_SLOTS - 1; k >= 0; k--) begin
      if (!slot_allocated[k]) begin
        found = 1'b1;
        given = esm_pkg::SLOT_W'(k + 1);
      end
    end
  end

  // addressed slot decode
  assign idx_ok = (in_q.effect_index != 8'd0) &&
                  (in_q.effect_index <= 8'(esm_pkg::MAX_SLOTS));
  assign sel = esm_pkg::slot_mask_t'(1) << (in_q.effect_index - 8'd1);
  assign credit_sum = {1'b0, pool_available} + 17'(block_cost);

  // command execution
  always_comb begin
    slot_allocated_next  = slot_allocated;
    slot_playing_next    = slot_playing;
    pool_available_next  = pool_available;
    actuator_enable_next = actuator_enable;
    pause_flag_next      = pause_flag;
    status_next          = esm_pkg::ST_OK;
    unique case (esm_pkg::cmd_t'(in_q.cmd))
      esm_pkg::CMD_CREATE: begin
        if (!found) begin
          status_next = esm_pkg::ST_FULL;
        end else begin
          slot_allocated_next = slot_allocated | (esm_pkg::slot_mask_t'(1) << (given - 1'b1));
          slot_playing_next   = slot_playing & ~(esm_pkg::slot_mask_t'(1) << (given - 1'b1));
          pool_available_next = (pool_available > {4'd0, block_cost}) ?
                                (pool_available - {4'd0, block_cost}) : 16'd0;
        end
      end
      esm_pkg::CMD_START, esm_pkg::CMD_START_SOLO: begin
        if (!idx_ok || (slot_allocated & sel) == '0) begin
          status_next = esm_pkg::ST_BAD;
        end else if (esm_pkg::cmd_t'(in_q.cmd) == esm_pkg::CMD_START_SOLO) begin
          slot_playing_next = sel;
        end else begin
          slot_playing_next = slot_playing | sel;
        end
      end
      esm_pkg::CMD_STOP: begin
        if (!idx_ok) begin
          status_next = esm_pkg::ST_BAD;
        end else begin
          slot_playing_next = slot_playing & ~sel;
        end
      end
      esm_pkg::CMD_FREE: begin
        priority if (in_q.effect_index == esm_pkg::FREE_ALL_INDEX) begin
          slot_allocated_next = '0;
          slot_playing_next   = '0;
          pool_available_next = pool_total;
        end else if (!idx_ok) begin
          status_next = esm_pkg::ST_BAD;
        end else if ((slot_allocated & sel) != '0) begin
          slot_allocated_next = slot_allocated & ~sel;
          slot_playing_next   = slot_playing & ~sel;
          pool_available_next = (credit_sum > {1'b0, pool_total}) ?
                                pool_total : credit_sum[15:0];
        end else begin
          status_next = esm_pkg::ST_OK;
        end
      end
      esm_pkg::CMD_FREE_ALL: begin
        slot_allocated_next = '0;
        slot_playing_next   = '0;
        pool_available_next = pool_total;
      end
      esm_pkg::CMD_ENABLE:   actuator_enable_next = 1'b1;
      esm_pkg::CMD_DISABLE:  actuator_enable_next = 1'b0;
      esm_pkg::CMD_STOP_ALL: slot_playing_next = '0;
      esm_pkg::CMD_PAUSE:    pause_flag_next = 1'b1;
      esm_pkg::CMD_RESUME:   pause_flag_next = 1'b0;
      default:               status_next = esm_pkg::ST_BAD;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_allocated  <= '0;
      slot_playing    <= '0;
      pool_available  <= 16'd0;
      actuator_enable <= 1'b1;
      pause_flag      <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= in_valid;
      if (in_valid) begin
        slot_allocated  <= slot_allocated_next;
        slot_playing    <= slot_playing_next;
        pool_available  <= pool_available_next;
        actuator_enable <= actuator_enable_next;
        pause_flag      <= pause_flag_next;
      end
    end
    if (in_valid) begin
      result.status         <= status_next;
      result.new_index      <= (esm_pkg::cmd_t'(in_q.cmd) == esm_pkg::CMD_CREATE) ?
                               5'(given) : 5'd0;
      result.pool_left      <= pool_available_next;
      result.allocated_mask <= 16'(slot_allocated_next);
      result.playing_mask   <= 16'(slot_playing_next);
      result.actuators_on   <= actuator_enable_next;
      result.paused         <= pause_flag_next;
    end
  end

  // checks
  `ESM_ASSERT_IMPL(a_play_needs_alloc, 1'b1, (slot_playing & ~slot_allocated) == '0)
  `ESM_ASSERT_NEXT(a_cmd_gives_result, in_valid, result_valid)
  `ESM_ASSERT_IMPL(a_full_no_slot, result_valid && result.status == esm_pkg::ST_FULL, result.new_index == 5'd0)
  `ESM_ASSERT_IMPL(a_slot_means_ok, result_valid && result.new_index != 5'd0, result.status == esm_pkg::ST_OK)

endmodule
`default_nettype wire
